>>> src/lfc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lfc_pkg
// Shared types and constants of the long FIR convolver: op codes, register
// map and fixed field widths.
// ----------------------------------------------------------------------------
package lfc_pkg;

   localparam int SAMPLE_W    = 16;
   localparam int TAP_IDX_W   = 10;
   localparam int TAP_CNT_W   = 11;
   localparam int ACC_W       = 48;
   localparam int PROD_W      = 2 * SAMPLE_W;
   localparam int REQ_DATA_W  = 48;
   localparam int RSP_DATA_W  = 16;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;

   // register index, taken from paddr above the byte offset
   localparam logic [0:0] REG_TAP_COUNT = 1'b0;

   typedef enum logic [1:0] {
      OP_SAMPLE   = 2'd0,
      OP_LOAD_TAP = 2'd1,
      OP_CLEAR    = 2'd2,
      OP_NONE     = 2'd3
   } op_type;

endpackage : lfc_pkg
`default_nettype wire

>>> src/lfc_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lfc_ram
// Generic single-clock RAM, one write port and one read port, registered read.
// ----------------------------------------------------------------------------
module lfc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  wire logic                                     clock,
   input  wire logic                                     wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                         wr_data,
   input  wire logic                                     rd_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output      logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule : lfc_ram
`default_nettype wire

>>> src/long_fir_convolver.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// long_fir_convolver
// Direct-form long FIR filter with runtime-loadable taps. Taps and sample
// history live in two RAMs; one multiply-accumulate is done per tap per cycle.
// ----------------------------------------------------------------------------
// Sequence: with n = min(tap_count, MAX_TAPS), a sample beat runs n tap and
//   history reads, drains, rounds and saturates, then waits while an earlier
//   result is still held; tap load, clear and unused ops finish on acceptance.
// Flow: no new beat is taken until a sample's result is loaded, as the
//   single read port of each RAM feeds one multiplier in turn.
// Reset: synchronous; the tap RAM is swept to zero, all MAX_TAPS entries,
//   while req_tready stays low; configuration writes are taken meanwhile.
// ----------------------------------------------------------------------------
module long_fir_convolver #(
   parameter int MAX_TAPS = 1024
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // input beats: tdata = tap_index[9:0], tap_value[25:10], in_sample[41:26],
   // zero fill [47:42]; tuser = op[1:0]
   input  wire logic                               req_tvalid,
   output      logic                               req_tready,
   input  wire logic [lfc_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  wire logic [1:0]                         req_tuser,
   // result beats: tdata = out_sample[15:0]; tuser = saturated[0]
   output      logic                               rsp_tvalid,
   input  wire logic                               rsp_tready,
   output      logic [lfc_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output      logic                               rsp_tuser,
   // configuration port
   input  wire logic                               csr_psel,
   input  wire logic                               csr_penable,
   input  wire logic                               csr_pwrite,
   input  wire logic [lfc_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  wire logic [lfc_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output      logic [lfc_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output      logic                               csr_pready
);

   import lfc_pkg::*;

   // address width of both RAMs, and a count width that can hold MAX_TAPS
   localparam int AW    = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
   localparam int CNT_W = $clog2(MAX_TAPS + 1);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MAC,
      ST_DRAIN,
      ST_ROUND,
      ST_SAT
   } state_type;

   // unpack the request beat
   op_type                       req_op;
   logic [TAP_IDX_W-1:0]         req_tap_index;
   logic [SAMPLE_W-1:0]          req_tap_value;
   logic [SAMPLE_W-1:0]          req_in_sample;
   logic                         req_accept;
   logic                         tap_index_ok;

   assign req_op        = op_type'(req_tuser);
   assign req_tap_index = req_tdata[TAP_IDX_W-1:0];
   assign req_tap_value = req_tdata[TAP_IDX_W +: SAMPLE_W];
   assign req_in_sample = req_tdata[TAP_IDX_W + SAMPLE_W +: SAMPLE_W];
   assign tap_index_ok  = int'(req_tap_index) < MAX_TAPS;

   // control state
   state_type                    state_ff, state_in;
   logic [AW-1:0]                clr_ff, clr_in;
   logic [AW-1:0]                ptr_ff, ptr_in;
   logic [AW-1:0]                slot_ff, slot_in;
   logic [CNT_W-1:0]             fill_ff, fill_in;
   logic [CNT_W-1:0]             n_ff, n_in;
   logic [CNT_W-1:0]             k_ff, k_in;
   logic [TAP_CNT_W-1:0]         tap_count_ff;
   logic                         issue_ff, issue_in;
   logic                         use_ff, use_in;
   logic                         p2_ff;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_load;

   // datapath payload
   logic signed [PROD_W-1:0]     prod_ff;
   logic signed [ACC_W-1:0]      acc_ff;
   logic signed [ACC_W-1:0]      rnd_ff;
   logic [SAMPLE_W-1:0]          rsp_data_ff;
   logic                         rsp_sat_ff;

   // RAM ports
   logic                         tap_we;
   logic [AW-1:0]                tap_waddr;
   logic [SAMPLE_W-1:0]          tap_wdata;
   logic [SAMPLE_W-1:0]          tap_rdata;
   logic                         hist_we;
   logic [SAMPLE_W-1:0]          hist_rdata;

   // rounding and saturation of the biased sum
   logic                         rnd_fits;
   logic [SAMPLE_W-1:0]          sat_value;
   logic                         sat_flag;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;

   // ------------------------------------------------------------------------
   // Configuration port: one register, tap_count, at byte address 0.
   // ------------------------------------------------------------------------
   logic csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[CSR_ADDR_W-1:2] == REG_TAP_COUNT) begin
         csr_prdata = {{(CSR_DATA_W - TAP_CNT_W){1'b0}}, tap_count_ff};
      end
   end

   // ------------------------------------------------------------------------
   // Sequencer. The history needs no clearing pass: after a clear the
   // pointer restarts at slot zero, so an entry k samples back holds live
   // data exactly when k is below the fill count. Older slots give zero products.
   // ------------------------------------------------------------------------
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      ptr_in       = ptr_ff;
      slot_in      = slot_ff;
      fill_in      = fill_ff;
      n_in         = n_ff;
      k_in         = k_ff;
      issue_in     = 1'b0;
      use_in       = 1'b0;
      rsp_load     = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      tap_we       = 1'b0;
      tap_waddr    = AW'(int'(req_tap_index));
      tap_wdata    = req_tap_value;
      hist_we      = 1'b0;

      unique case (state_ff)
         ST_CLEAR: begin
            // zero the tap RAM, one entry a cycle
            tap_we    = 1'b1;
            tap_waddr = clr_ff;
            tap_wdata = '0;
            if (clr_ff == AW'(MAX_TAPS - 1)) begin
               state_in = ST_IDLE;
            end else begin
               clr_in = clr_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               unique case (req_op)
                  OP_SAMPLE: begin
                     hist_we = 1'b1;
                     if (fill_ff != CNT_W'(MAX_TAPS)) begin
                        fill_in = fill_ff + 1'b1;
                     end
                     if (int'(tap_count_ff) > MAX_TAPS) begin
                        n_in = CNT_W'(MAX_TAPS);
                     end else begin
                        n_in = CNT_W'(tap_count_ff);
                     end
                     k_in     = '0;
                     slot_in  = ptr_ff;
                     ptr_in   = (ptr_ff == AW'(MAX_TAPS - 1)) ? '0 : ptr_ff + 1'b1;
                     state_in = ST_MAC;
                  end
                  OP_LOAD_TAP: begin
                     tap_we  = tap_index_ok;
                     ptr_in  = '0;
                     fill_in = '0;
                  end
                  OP_CLEAR: begin
                     ptr_in  = '0;
                     fill_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_MAC: begin
            // issue one tap and one history read per cycle
            if (k_ff < n_ff) begin
               issue_in = 1'b1;
               use_in   = (k_ff < fill_ff);
               k_in     = k_ff + 1'b1;
               slot_in  = (slot_ff == '0) ? AW'(MAX_TAPS - 1) : slot_ff - 1'b1;
            end else begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // wait for the last product to reach the accumulator
            if (!issue_ff && !p2_ff) begin
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            state_in = ST_SAT;
         end
         ST_SAT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_load     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         ptr_ff       <= '0;
         slot_ff      <= '0;
         fill_ff      <= '0;
         n_ff         <= '0;
         k_ff         <= '0;
         issue_ff     <= 1'b0;
         use_ff       <= 1'b0;
         p2_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         ptr_ff       <= ptr_in;
         slot_ff      <= slot_in;
         fill_ff      <= fill_in;
         n_ff         <= n_in;
         k_ff         <= k_in;
         issue_ff     <= issue_in;
         use_ff       <= use_in;
         p2_ff        <= issue_ff;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_count_ff <= '0;
      end else if (csr_write && (csr_paddr[CSR_ADDR_W-1:2] == REG_TAP_COUNT)) begin
         tap_count_ff <= csr_pwdata[TAP_CNT_W-1:0];
      end
   end

   // ------------------------------------------------------------------------
   // Memories
   // ------------------------------------------------------------------------
   lfc_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (MAX_TAPS)
   ) u_tap_ram (
      .clock   (clock),
      .wr_en   (tap_we),
      .wr_addr (tap_waddr),
      .wr_data (tap_wdata),
      .rd_en   (issue_in),
      .rd_addr (k_ff[AW-1:0]),
      .rd_data (tap_rdata)
   );

   lfc_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (MAX_TAPS)
   ) u_hist_ram (
      .clock   (clock),
      .wr_en   (hist_we),
      .wr_addr (ptr_ff),
      .wr_data (req_in_sample),
      .rd_en   (issue_in),
      .rd_addr (slot_ff),
      .rd_data (hist_rdata)
   );

   // ------------------------------------------------------------------------
   // Datapath: multiply, accumulate, round, saturate.
   // ------------------------------------------------------------------------
   // the biased sum fits 16 bits after the shift when bits 47..30 agree
   assign rnd_fits = (rnd_ff[ACC_W-1:30] == {(ACC_W - 30){rnd_ff[30]}});

   always_comb begin
      sat_value = rnd_ff[30:15];
      sat_flag  = 1'b0;
      if (!rnd_fits) begin
         sat_flag  = 1'b1;
         sat_value = rnd_ff[ACC_W-1] ? 16'h8000 : 16'h7fff;
      end
   end

   always_ff @(posedge clock) begin
      // drop products of slots not written since the last clear
      if (use_ff) begin
         prod_ff <= $signed(tap_rdata) * $signed(hist_rdata);
      end else begin
         prod_ff <= '0;
      end

      if (req_accept && (req_op == OP_SAMPLE)) begin
         acc_ff <= '0;
      end else if (p2_ff) begin
         acc_ff <= acc_ff + {{(ACC_W - PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
      end

      // add one half LSB of the output before the floor shift
      if (state_ff == ST_ROUND) begin
         rnd_ff <= acc_ff + ACC_W'(16384);
      end

      if (rsp_load) begin
         rsp_data_ff <= sat_value;
         rsp_sat_ff  <= sat_flag;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_sat_ff;

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------
   a_fill_bound : assert property (@(posedge clock) disable iff (reset)
      int'(fill_ff) <= MAX_TAPS)
      else $error("history fill count above MAX_TAPS");

   a_k_bound : assert property (@(posedge clock) disable iff (reset)
      k_ff <= n_ff)
      else $error("tap counter ran past the tap count");

   a_round_empty : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUND) |-> (!issue_ff && !p2_ff))
      else $error("rounding started with products in flight");

   a_no_issue_idle : assert property (@(posedge clock) disable iff (reset)
      issue_ff |-> $past(state_ff == ST_MAC))
      else $error("RAM read issued outside the accumulate phase");

endmodule : long_fir_convolver
`default_nettype wire
